>>> src/rsm_pkg.sv
// shared constants, opcodes, fault codes and control structs of the stack machine
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int CNT_W         = SP_W + 1;
  localparam int SYMBOL_SLOTS  = 256;
  localparam int SLOT_W        = 8;
  localparam int ARRAY_LENGTH  = 16;
  localparam int IDX_W         = $clog2(ARRAY_LENGTH);
  localparam int ARRAY_CELLS   = SYMBOL_SLOTS * ARRAY_LENGTH;
  localparam int CELL_W        = SLOT_W + IDX_W;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int ADDR_W        = 13;
  localparam int TGT_W         = 12;
  localparam int STEP_W        = 19;
  localparam int DATA_W        = 32;
  localparam int KIND_W        = 5;

  localparam logic [1:0] TAG_INT  = 2'd0;
  localparam logic [1:0] TAG_VAR  = 2'd1;
  localparam logic [1:0] TAG_ELEM = 2'd2;

  localparam logic [1:0] RS_RUN  = 2'd0;
  localparam logic [1:0] RS_DONE = 2'd1;
  localparam logic [1:0] RS_HALT = 2'd2;

  localparam logic [3:0] FLT_NONE    = 4'd0;
  localparam logic [3:0] FLT_UNDER   = 4'd1;
  localparam logic [3:0] FLT_OVER    = 4'd2;
  localparam logic [3:0] FLT_TYPE    = 4'd3;
  localparam logic [3:0] FLT_DIVZ    = 4'd4;
  localparam logic [3:0] FLT_UNASGN  = 4'd5;
  localparam logic [3:0] FLT_RANGE   = 4'd6;
  localparam logic [3:0] FLT_NEGIDX  = 4'd7;
  localparam logic [3:0] FLT_TARGET  = 4'd8;
  localparam logic [3:0] FLT_OPERAND = 4'd9;
  localparam logic [3:0] FLT_UNKNOWN = 4'd10;
  localparam logic [3:0] FLT_STEPS   = 4'd11;

  localparam logic [KIND_W-1:0] OP_PUSHC  = 5'd0;
  localparam logic [KIND_W-1:0] OP_PUSHV  = 5'd1;
  localparam logic [KIND_W-1:0] OP_PUSHA  = 5'd2;
  localparam logic [KIND_W-1:0] OP_ADD    = 5'd3;
  localparam logic [KIND_W-1:0] OP_SUB    = 5'd4;
  localparam logic [KIND_W-1:0] OP_MUL    = 5'd5;
  localparam logic [KIND_W-1:0] OP_DIV    = 5'd6;
  localparam logic [KIND_W-1:0] OP_EQ     = 5'd7;
  localparam logic [KIND_W-1:0] OP_NE     = 5'd8;
  localparam logic [KIND_W-1:0] OP_GT     = 5'd9;
  localparam logic [KIND_W-1:0] OP_LT     = 5'd10;
  localparam logic [KIND_W-1:0] OP_ASSIGN = 5'd11;
  localparam logic [KIND_W-1:0] OP_INDEX  = 5'd12;
  localparam logic [KIND_W-1:0] OP_READ   = 5'd13;
  localparam logic [KIND_W-1:0] OP_WRITE  = 5'd14;
  localparam logic [KIND_W-1:0] OP_JUMP   = 5'd15;
  localparam logic [KIND_W-1:0] OP_JF     = 5'd16;

  typedef struct packed {
    logic [1:0]        tag;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] val;
  } rsm_ent_t;

  typedef struct packed {
    logic load;
    logic start;
    logic pop;
    logic pop_data;
    logic raw;
    logic deref;
    logic exec;
    logic div_wait;
    logic push;
    logic fin;
    logic out_load;
    logic clear;
  } rsm_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              run_ok;
    logic              pop_empty;
    logic              pop_fault;
    logic              need_deref;
    logic              exec_fault;
    logic              div_go;
    logic              push_go;
    logic              div_done;
    logic              clear_last;
    logic              out_busy;
  } rsm_stat_t;

endpackage
`default_nettype wire

>>> src/rsm_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none
module rsm_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rsm_pkg::DATA_W-1:0] dividend,
  input  wire logic [rsm_pkg::DATA_W-1:0] divisor,
  output logic                           done,
  output logic [rsm_pkg::DATA_W-1:0]     quotient
);
  import rsm_pkg::*;

  localparam int CNT_BITS = $clog2(DATA_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   quo_r;
  logic [DATA_W-1:0]   dvs_r;
  logic                neg_r;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     diff;

  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(DATA_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_r <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule
`default_nettype wire

>>> src/rsm_datapath.sv
// datapath: operand stack, variable and array stores, alu, run state and output register
`timescale 1ns / 1ps
`default_nettype none
module rsm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rsm_pkg::rsm_cmd_t           cmd,
  output rsm_pkg::rsm_stat_t               st,
  input  wire logic [rsm_pkg::KIND_W-1:0]  in_kind,
  input  wire logic                        in_operand_present,
  input  wire logic signed [31:0]          in_immediate,
  input  wire logic [rsm_pkg::SLOT_W-1:0]  in_symbol_slot,
  input  wire logic [rsm_pkg::TGT_W-1:0]   in_jump_target,
  input  wire logic signed [31:0]          in_read_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rsm_pkg::ADDR_W-1:0]       out_next_address,
  output logic                             out_write_valid,
  output logic signed [31:0]               out_write_value,
  output logic [1:0]                       out_run_status,
  output logic [3:0]                       out_fault_code,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rsm_pkg::ADDR_W-1:0]  cfg_data
);
  import rsm_pkg::*;

  // item
  logic [KIND_W-1:0] kind_r;
  logic              has_r;
  logic [DATA_W-1:0] imm_r;
  logic [SLOT_W-1:0] sym_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [DATA_W-1:0] rdv_r;

  // architectural state
  logic [ADDR_W-1:0] eff_r;
  logic [STEP_W-1:0] limit_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] next_r;
  logic [STEP_W-1:0] steps_r;
  logic [1:0]        run_r;
  logic [3:0]        fault_r;
  logic [SYMBOL_SLOTS-1:0] assigned_r;
  logic              wvalid_r;
  logic [DATA_W-1:0] wval_r;

  // working registers
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  rsm_ent_t          tgt_ent_r;
  rsm_ent_t          push_r;
  logic [CELL_W-1:0] clr_r;

  // memories
  rsm_ent_t          stk_mem [STACK_DEPTH];
  rsm_ent_t          stk_q;
  logic [DATA_W-1:0] var_mem [SYMBOL_SLOTS];
  logic [DATA_W-1:0] var_q;
  logic [DATA_W-1:0] arr_mem [ARRAY_CELLS];
  logic [DATA_W-1:0] arr_q;

  // output register
  logic              ovalid_r;
  logic [ADDR_W-1:0] oaddr_r;
  logic              owv_r;
  logic [DATA_W-1:0] owval_r;
  logic [1:0]        orun_r;
  logic [3:0]        oflt_r;

  // config path
  logic [ADDR_W-1:0] eff_in;
  logic [STEP_W-1:0] eff_ext;
  logic [STEP_W-1:0] limit_in;

  assign cfg_ready = 1'b1;
  assign eff_in    = (cfg_data > ADDR_W'(PROGRAM_DEPTH)) ? ADDR_W'(PROGRAM_DEPTH) : cfg_data;
  assign eff_ext   = STEP_W'(eff_in);
  assign limit_in  = (eff_ext << 6) + (eff_ext << 5) + (eff_ext << 2);

  // pop path
  logic pd_fault;
  logic pd_deref;
  logic [3:0] pd_code;

  always_comb begin
    pd_fault = 1'b0;
    pd_code  = FLT_NONE;
    pd_deref = 1'b0;
    if (!cmd.raw) begin
      if (stk_q.tag == TAG_VAR) begin
        if (!assigned_r[stk_q.slot]) begin
          pd_fault = 1'b1;
          pd_code  = FLT_UNASGN;
        end else begin
          pd_deref = 1'b1;
        end
      end else if (stk_q.tag != TAG_INT) begin
        if (stk_q.val >= DATA_W'(ARRAY_LENGTH)) begin
          pd_fault = 1'b1;
          pd_code  = FLT_RANGE;
        end else begin
          pd_deref = 1'b1;
        end
      end
    end
  end

  // execute path
  logic              ex_fault;
  logic [3:0]        ex_code;
  logic              ex_div;
  logic              ex_push;
  rsm_ent_t          ex_ent;
  logic              ex_var_we;
  logic              ex_arr_we;
  logic [DATA_W-1:0] ex_sv;
  logic              ex_wv;
  logic              ex_jump;
  logic [DATA_W-1:0] prod;

  assign prod = a_r * b_r;

  always_comb begin
    ex_fault  = 1'b0;
    ex_code   = FLT_NONE;
    ex_div    = 1'b0;
    ex_push   = 1'b0;
    ex_ent    = '{tag: TAG_INT, slot: '0, val: '0};
    ex_var_we = 1'b0;
    ex_arr_we = 1'b0;
    ex_sv     = (kind_r == OP_READ) ? rdv_r : a_r;
    ex_wv     = 1'b0;
    ex_jump   = 1'b0;
    case (kind_r) inside
      OP_PUSHC: begin
        if (!has_r) begin
          ex_fault = 1'b1;
          ex_code  = FLT_OPERAND;
        end else begin
          ex_push    = 1'b1;
          ex_ent.val = imm_r;
        end
      end
      OP_PUSHV, OP_PUSHA: begin
        if (!has_r) begin
          ex_fault = 1'b1;
          ex_code  = FLT_OPERAND;
        end else begin
          ex_push     = 1'b1;
          ex_ent.tag  = TAG_VAR;
          ex_ent.slot = sym_r;
        end
      end
      OP_ADD: begin
        ex_push    = 1'b1;
        ex_ent.val = a_r + b_r;
      end
      OP_SUB: begin
        ex_push    = 1'b1;
        ex_ent.val = a_r - b_r;
      end
      OP_MUL: begin
        ex_push    = 1'b1;
        ex_ent.val = prod;
      end
      OP_DIV: begin
        if (b_r == '0) begin
          ex_fault = 1'b1;
          ex_code  = FLT_DIVZ;
        end else begin
          ex_div = 1'b1;
        end
      end
      OP_EQ: begin
        ex_push    = 1'b1;
        ex_ent.val = DATA_W'(a_r == b_r);
      end
      OP_NE: begin
        ex_push    = 1'b1;
        ex_ent.val = DATA_W'(a_r != b_r);
      end
      OP_GT: begin
        ex_push    = 1'b1;
        ex_ent.val = DATA_W'($signed(a_r) > $signed(b_r));
      end
      OP_LT: begin
        ex_push    = 1'b1;
        ex_ent.val = DATA_W'($signed(a_r) < $signed(b_r));
      end
      OP_ASSIGN, OP_READ: begin
        if (tgt_ent_r.tag == TAG_VAR) begin
          ex_var_we = 1'b1;
        end else if (tgt_ent_r.tag == TAG_ELEM) begin
          if (tgt_ent_r.val >= DATA_W'(ARRAY_LENGTH)) begin
            ex_fault = 1'b1;
            ex_code  = FLT_RANGE;
          end else begin
            ex_arr_we = 1'b1;
          end
        end else begin
          ex_fault = 1'b1;
          ex_code  = FLT_TYPE;
        end
      end
      OP_INDEX: begin
        if (tgt_ent_r.tag != TAG_VAR) begin
          ex_fault = 1'b1;
          ex_code  = FLT_TYPE;
        end else if (a_r[DATA_W-1]) begin
          ex_fault = 1'b1;
          ex_code  = FLT_NEGIDX;
        end else begin
          ex_push     = 1'b1;
          ex_ent.tag  = TAG_ELEM;
          ex_ent.slot = tgt_ent_r.slot;
          ex_ent.val  = a_r;
        end
      end
      OP_WRITE: ex_wv = 1'b1;
      OP_JUMP: begin
        if (!has_r) begin
          ex_fault = 1'b1;
          ex_code  = FLT_TARGET;
        end else begin
          ex_jump = 1'b1;
        end
      end
      OP_JF: begin
        if (!has_r) begin
          ex_fault = 1'b1;
          ex_code  = FLT_TARGET;
        end else begin
          ex_jump = (a_r == '0);
        end
      end
      default: begin
        ex_fault = 1'b1;
        ex_code  = FLT_UNKNOWN;
      end
    endcase
  end

  // divider
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  rsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && ex_div),
    .dividend (a_r),
    .divisor  (b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r      <= ADDR_W'(1);
      limit_r    <= STEP_W'(100);
      count_r    <= '0;
      addr_r     <= '0;
      steps_r    <= '0;
      run_r      <= RS_RUN;
      fault_r    <= FLT_NONE;
      assigned_r <= '0;
      wvalid_r   <= 1'b0;
      clr_r      <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        eff_r   <= eff_in;
        limit_r <= limit_in;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.load) begin
        wvalid_r <= 1'b0;
      end
      if (cmd.start && run_r == RS_RUN) begin
        if (steps_r >= limit_r) begin
          run_r   <= RS_HALT;
          fault_r <= FLT_STEPS;
        end else if (addr_r >= eff_r) begin
          run_r <= RS_DONE;
        end else begin
          steps_r <= steps_r + 1'b1;
        end
      end
      if (cmd.pop) begin
        if (count_r == '0) begin
          fault_r <= FLT_UNDER;
        end else begin
          count_r <= count_r - 1'b1;
        end
      end
      if (cmd.pop_data && pd_fault) begin
        fault_r <= pd_code;
      end
      if (cmd.exec) begin
        if (ex_fault) begin
          fault_r <= ex_code;
        end
        if (ex_var_we) begin
          assigned_r[tgt_ent_r.slot] <= 1'b1;
        end
        if (ex_wv) begin
          wvalid_r <= 1'b1;
        end
      end
      if (cmd.push) begin
        if (count_r >= CNT_W'(STACK_DEPTH)) begin
          fault_r <= FLT_OVER;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.fin) begin
        if (fault_r != FLT_NONE) begin
          run_r    <= RS_HALT;
          wvalid_r <= 1'b0;
        end else begin
          addr_r <= next_r;
          if (steps_r >= limit_r) begin
            run_r   <= RS_HALT;
            fault_r <= FLT_STEPS;
          end else if (next_r >= eff_r) begin
            run_r <= RS_DONE;
          end
        end
      end
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      has_r  <= in_operand_present;
      imm_r  <= in_immediate;
      sym_r  <= in_symbol_slot;
      tgt_r  <= in_jump_target;
      rdv_r  <= in_read_value;
      wval_r <= '0;
    end
    if (cmd.start) begin
      next_r <= addr_r + 1'b1;
    end
    if (cmd.pop_data) begin
      if (cmd.raw) begin
        tgt_ent_r <= stk_q;
      end else if (stk_q.tag == TAG_INT) begin
        a_r <= stk_q.val;
        b_r <= a_r;
      end
    end
    if (cmd.deref) begin
      a_r <= (stk_q.tag == TAG_VAR) ? var_q : arr_q;
      b_r <= a_r;
    end
    if (cmd.exec) begin
      push_r <= ex_ent;
      if (ex_jump) begin
        next_r <= ADDR_W'(tgt_r);
      end
      if (ex_wv) begin
        wval_r <= a_r;
      end
    end
    if (cmd.div_wait && div_done) begin
      push_r.val <= div_q;
    end
    if (cmd.fin && fault_r != FLT_NONE) begin
      wval_r <= '0;
    end
    if (cmd.out_load) begin
      oaddr_r <= addr_r;
      owv_r   <= wvalid_r;
      owval_r <= wval_r;
      orun_r  <= run_r;
      oflt_r  <= fault_r;
    end
  end

  // operand stack
  always_ff @(posedge clk) begin
    if (cmd.push && count_r < CNT_W'(STACK_DEPTH)) begin
      stk_mem[count_r[SP_W-1:0]] <= push_r;
    end
    if (cmd.pop) begin
      stk_q <= stk_mem[SP_W'(count_r - 1'b1)];
    end
  end

  // variable store
  always_ff @(posedge clk) begin
    if (cmd.exec && ex_var_we) begin
      var_mem[tgt_ent_r.slot] <= ex_sv;
    end
    var_q <= var_mem[stk_q.slot];
  end

  // array store
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      arr_mem[clr_r] <= '0;
    end else if (cmd.exec && ex_arr_we) begin
      arr_mem[{tgt_ent_r.slot, tgt_ent_r.val[IDX_W-1:0]}] <= ex_sv;
    end
    arr_q <= arr_mem[{stk_q.slot, stk_q.val[IDX_W-1:0]}];
  end

  always_comb begin
    st.kind       = kind_r;
    st.run_ok     = (run_r == RS_RUN) && (steps_r < limit_r) && (addr_r < eff_r);
    st.pop_empty  = (count_r == '0);
    st.pop_fault  = pd_fault;
    st.need_deref = pd_deref;
    st.exec_fault = ex_fault;
    st.div_go     = ex_div;
    st.push_go    = ex_push;
    st.div_done   = div_done;
    st.clear_last = (clr_r == CELL_W'(ARRAY_CELLS - 1));
    st.out_busy   = ovalid_r && !out_ready;
  end

  assign out_valid        = ovalid_r;
  assign out_next_address = oaddr_r;
  assign out_write_valid  = owv_r;
  assign out_write_value  = owval_r;
  assign out_run_status   = orun_r;
  assign out_fault_code   = oflt_r;

endmodule
`default_nettype wire

>>> src/rsm_ctrl.sv
// controller: sequences check, pops, dereference, execute, divide, push and result
`timescale 1ns / 1ps
`default_nettype none
module rsm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rsm_pkg::rsm_stat_t st,
  output rsm_pkg::rsm_cmd_t       cmd
);
  import rsm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_POPD  = 4'd4;
  localparam logic [3:0] S_DEREF = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] pops_r, pops_nxt;
  logic       raw_r, raw_nxt;
  logic [1:0] dec_pops;
  logic       dec_raw;

  always_comb begin
    unique case (st.kind) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_LT: begin
        dec_pops = 2'd2;
        dec_raw  = 1'b0;
      end
      OP_ASSIGN, OP_INDEX: begin
        dec_pops = 2'd2;
        dec_raw  = 1'b1;
      end
      OP_READ: begin
        dec_pops = 2'd1;
        dec_raw  = 1'b1;
      end
      OP_WRITE, OP_JF: begin
        dec_pops = 2'd1;
        dec_raw  = 1'b0;
      end
      default: begin
        dec_pops = 2'd0;
        dec_raw  = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    pops_nxt  = pops_r;
    raw_nxt   = raw_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.start = 1'b1;
        pops_nxt  = dec_pops;
        raw_nxt   = dec_raw;
        if (!st.run_ok) begin
          state_nxt = S_OUT;
        end else if (dec_pops != 2'd0) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = st.pop_empty ? S_FIN : S_POPD;
      end
      S_POPD: begin
        cmd.pop_data = 1'b1;
        cmd.raw      = (pops_r == 2'd1) && raw_r;
        if (st.pop_fault) begin
          state_nxt = S_FIN;
        end else if (st.need_deref) begin
          state_nxt = S_DEREF;
        end else begin
          pops_nxt  = pops_r - 1'b1;
          state_nxt = (pops_r == 2'd1) ? S_EXEC : S_POP;
        end
      end
      S_DEREF: begin
        cmd.deref = 1'b1;
        pops_nxt  = pops_r - 1'b1;
        state_nxt = (pops_r == 2'd1) ? S_EXEC : S_POP;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.exec_fault) begin
          state_nxt = S_FIN;
        end else if (st.div_go) begin
          state_nxt = S_DIV;
        end else if (st.push_go) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_wait = 1'b1;
        if (st.div_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pops_r  <= '0;
      raw_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pops_r  <= pops_nxt;
      raw_r   <= raw_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/rpn_stack_machine_executor.sv
// top level: rpn stack machine executor, controller plus datapath
// sequencing: an item that finds a halted or finished block goes from check straight to the result;
//   other items pass through pops, execute, push and finish as needed, a divide waiting on the divider
// throughput: one item at a time, next input transfer right after the result is loaded
// reset: synchronous active low; then a clear of all 4096 array store cells with in_ready low,
//   configuration writes taken throughout
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_machine_executor (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rsm_pkg::KIND_W-1:0]  in_kind,
  input  wire logic                        in_operand_present,
  input  wire logic signed [31:0]          in_immediate,
  input  wire logic [rsm_pkg::SLOT_W-1:0]  in_symbol_slot,
  input  wire logic [rsm_pkg::TGT_W-1:0]   in_jump_target,
  input  wire logic signed [31:0]          in_read_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rsm_pkg::ADDR_W-1:0]       out_next_address,
  output logic                             out_write_valid,
  output logic signed [31:0]               out_write_value,
  output logic [1:0]                       out_run_status,
  output logic [3:0]                       out_fault_code,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rsm_pkg::ADDR_W-1:0]  cfg_data
);
  import rsm_pkg::*;

  rsm_cmd_t  cmd;
  rsm_stat_t st;

  rsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rsm_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_kind            (in_kind),
    .in_operand_present (in_operand_present),
    .in_immediate       (in_immediate),
    .in_symbol_slot     (in_symbol_slot),
    .in_jump_target     (in_jump_target),
    .in_read_value      (in_read_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_address   (out_next_address),
    .out_write_valid    (out_write_valid),
    .out_write_value    (out_write_value),
    .out_run_status     (out_run_status),
    .out_fault_code     (out_fault_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

endmodule
`default_nettype wire

>>> verif/tb_rpn_stack_machine_executor.sv
// testbench for the rpn stack machine executor: random programs checked against a local predictor
`timescale 1ns / 1ps
module tb_rpn_stack_machine_executor;
  import rsm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              opnd;
    logic [31:0]       imm;
    logic [SLOT_W-1:0] sym;
    logic [TGT_W-1:0]  tgt;
    logic [31:0]       rdv;
  } instr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              wv;
    logic [31:0]       wval;
    logic [1:0]        rs;
    logic [3:0]        fc;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic in_operand_present = 1'b0;
  logic signed [31:0] in_immediate = '0;
  logic [SLOT_W-1:0] in_symbol_slot = '0;
  logic [TGT_W-1:0] in_jump_target = '0;
  logic signed [31:0] in_read_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] out_next_address;
  logic out_write_valid;
  logic signed [31:0] out_write_value;
  logic [1:0] out_run_status;
  logic [3:0] out_fault_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  rpn_stack_machine_executor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_operand_present(in_operand_present), .in_immediate(in_immediate),
    .in_symbol_slot(in_symbol_slot), .in_jump_target(in_jump_target),
    .in_read_value(in_read_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_next_address(out_next_address),
    .out_write_valid(out_write_valid), .out_write_value(out_write_value),
    .out_run_status(out_run_status), .out_fault_code(out_fault_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // machine state as predicted
  logic [1:0]        m_tag  [STACK_DEPTH];
  logic [SLOT_W-1:0] m_slot [STACK_DEPTH];
  logic [31:0]       m_val  [STACK_DEPTH];
  int unsigned       m_cnt, m_addr, m_steps, m_len;
  logic [31:0]       m_vars [SYMBOL_SLOTS];
  bit                m_asg  [SYMBOL_SLOTS];
  logic [31:0]       m_arr  [ARRAY_CELLS];
  logic [1:0]        m_rs;
  logic [3:0]        m_flt;

  instr_t  instr_q[$];
  status_t status_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  function automatic void raise(logic [3:0] c);
    if (m_flt == FLT_NONE) m_flt = c;
  endfunction

  function automatic void push_ent(logic [1:0] tag, logic [SLOT_W-1:0] slot, logic [31:0] v);
    if (m_flt != FLT_NONE) return;
    if (m_cnt >= STACK_DEPTH) begin
      raise(FLT_OVER);
      return;
    end
    m_tag[m_cnt] = tag;
    m_slot[m_cnt] = slot;
    m_val[m_cnt] = v;
    m_cnt++;
  endfunction

  function automatic bit pop_ent(output logic [1:0] tag, output logic [SLOT_W-1:0] slot,
                                 output logic [31:0] v);
    tag = TAG_INT;
    slot = '0;
    v = '0;
    if (m_flt != FLT_NONE) return 0;
    if (m_cnt == 0) begin
      raise(FLT_UNDER);
      return 0;
    end
    m_cnt--;
    tag = m_tag[m_cnt];
    slot = m_slot[m_cnt];
    v = m_val[m_cnt];
    return 1;
  endfunction

  function automatic logic [31:0] pop_value();
    logic [1:0] tag;
    logic [SLOT_W-1:0] slot;
    logic [31:0] v;
    if (!pop_ent(tag, slot, v)) return '0;
    if (tag == TAG_INT) return v;
    if (tag == TAG_VAR) begin
      if (!m_asg[slot]) begin
        raise(FLT_UNASGN);
        return '0;
      end
      return m_vars[slot];
    end
    if (v >= ARRAY_LENGTH) begin
      raise(FLT_RANGE);
      return '0;
    end
    return m_arr[slot * ARRAY_LENGTH + v];
  endfunction

  function automatic void store_to(logic [1:0] tag, logic [SLOT_W-1:0] slot, logic [31:0] idx,
                                   logic [31:0] v);
    if (m_flt != FLT_NONE) return;
    if (tag == TAG_VAR) begin
      m_vars[slot] = v;
      m_asg[slot] = 1;
    end else if (tag == TAG_ELEM) begin
      if (idx >= ARRAY_LENGTH) raise(FLT_RANGE);
      else m_arr[slot * ARRAY_LENGTH + idx] = v;
    end else begin
      raise(FLT_TYPE);
    end
  endfunction

  function automatic void check_run();
    int unsigned eff;
    eff = (m_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : m_len;
    if (m_rs != RS_RUN) return;
    if (m_steps >= eff * 100) begin
      m_rs = RS_HALT;
      m_flt = FLT_STEPS;
    end else if (m_addr >= eff) begin
      m_rs = RS_DONE;
    end
  endfunction

  function automatic status_t execute(instr_t it);
    status_t r;
    int unsigned cur;
    logic [31:0] a, b, q, ua, ub;
    logic [1:0] tag;
    logic [SLOT_W-1:0] slot;
    logic [31:0] idx;
    r = '0;
    check_run();
    if (m_rs == RS_RUN) begin
      cur = m_addr;
      m_addr = cur + 1;
      m_steps++;
      case (it.kind)
        OP_PUSHC: if (!it.opnd) raise(FLT_OPERAND); else push_ent(TAG_INT, '0, it.imm);
        OP_PUSHV, OP_PUSHA: if (!it.opnd) raise(FLT_OPERAND); else push_ent(TAG_VAR, it.sym, '0);
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_LT: begin
          b = pop_value();
          a = pop_value();
          if (m_flt == FLT_NONE) begin
            q = '0;
            case (it.kind)
              OP_ADD: q = a + b;
              OP_SUB: q = a - b;
              OP_MUL: q = a * b;
              OP_DIV: begin
                if (b == 0) raise(FLT_DIVZ);
                else begin
                  ua = a[31] ? -a : a;
                  ub = b[31] ? -b : b;
                  q = ua / ub;
                  if (a[31] != b[31]) q = -q;
                end
              end
              OP_EQ: q = {31'd0, a == b};
              OP_NE: q = {31'd0, a != b};
              OP_GT: q = {31'd0, $signed(a) > $signed(b)};
              default: q = {31'd0, $signed(a) < $signed(b)};
            endcase
            push_ent(TAG_INT, '0, q);
          end
        end
        OP_ASSIGN: begin
          a = pop_value();
          if (pop_ent(tag, slot, idx)) store_to(tag, slot, idx, a);
        end
        OP_INDEX: begin
          a = pop_value();
          if (pop_ent(tag, slot, idx)) begin
            if (tag != TAG_VAR) raise(FLT_TYPE);
            else if (a[31]) raise(FLT_NEGIDX);
            else push_ent(TAG_ELEM, slot, a);
          end
        end
        OP_READ: if (pop_ent(tag, slot, idx)) store_to(tag, slot, idx, it.rdv);
        OP_WRITE: begin
          a = pop_value();
          if (m_flt == FLT_NONE) begin
            r.wv = 1'b1;
            r.wval = a;
          end
        end
        OP_JUMP: if (!it.opnd) raise(FLT_TARGET); else m_addr = it.tgt;
        OP_JF: begin
          a = pop_value();
          if (m_flt == FLT_NONE) begin
            if (!it.opnd) raise(FLT_TARGET);
            else if (a == 0) m_addr = it.tgt;
          end
        end
        default: raise(FLT_UNKNOWN);
      endcase
      if (m_flt != FLT_NONE) begin
        m_rs = RS_HALT;
        m_addr = cur;
        r.wv = 1'b0;
        r.wval = '0;
      end else begin
        check_run();
      end
    end
    r.addr = m_addr[ADDR_W-1:0];
    r.rs = m_rs;
    r.fc = m_flt;
    return r;
  endfunction

  function automatic instr_t rand_instr(logic [KIND_W-1:0] k);
    instr_t it;
    it.kind = k;
    it.opnd = 1'($urandom_range(1));
    it.imm = $urandom;
    it.sym = SLOT_W'($urandom);
    it.tgt = TGT_W'($urandom);
    it.rdv = $urandom;
    return it;
  endfunction

  function automatic void send(instr_t it);
    instr_q.push_back(it);
    status_q.push_back(execute(it));
  endfunction

  function automatic void op(logic [KIND_W-1:0] k);
    send(rand_instr(k));
  endfunction

  function automatic void push_imm(logic [31:0] v);
    instr_t it;
    it = rand_instr(OP_PUSHC);
    it.opnd = 1'b1;
    it.imm = v;
    send(it);
  endfunction

  function automatic void push_sym(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s);
    instr_t it;
    it = rand_instr(k);
    it.opnd = 1'b1;
    it.sym = s;
    send(it);
  endfunction

  function automatic void push_elem(logic [SLOT_W-1:0] s, logic [31:0] idx);
    push_sym(OP_PUSHA, s);
    push_imm(idx);
    op(OP_INDEX);
  endfunction

  function automatic void jump_to(logic [KIND_W-1:0] k, logic [TGT_W-1:0] t);
    instr_t it;
    it = rand_instr(k);
    it.opnd = 1'b1;
    it.tgt = t;
    send(it);
  endfunction

  function automatic void push_operand();
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom);
    case ($urandom_range(3))
      0: push_elem(s, $urandom_range(ARRAY_LENGTH - 1));
      1: if (m_asg[s]) push_sym(OP_PUSHV, s); else push_imm($urandom);
      2: push_imm($urandom_range(20) - 10);
      default: push_imm($urandom);
    endcase
  endfunction

  function automatic void arith(logic [KIND_W-1:0] k, logic [31:0] a, logic [31:0] b);
    push_imm(a);
    push_imm(b);
    op(k);
    op(OP_WRITE);
  endfunction

  function automatic void random_sequence();
    int n;
    logic [KIND_W-1:0] k;
    logic [SLOT_W-1:0] s;
    instr_t it;
    s = SLOT_W'($urandom);
    case ($urandom_range(7))
      0: begin
        push_sym(OP_PUSHV, s);
        push_operand();
        op(OP_ASSIGN);
      end
      1: begin
        if ($urandom_range(1)) push_sym(OP_PUSHV, s);
        else push_elem(s, $urandom_range(ARRAY_LENGTH - 1));
        op(OP_READ);
      end
      2: begin
        push_elem(s, $urandom_range(ARRAY_LENGTH - 1));
        push_operand();
        op(OP_ASSIGN);
      end
      3: begin
        push_operand();
        op(OP_WRITE);
      end
      4: begin
        push_operand();
        k = KIND_W'(OP_ADD + $urandom_range(7));
        if (k == OP_DIV) push_imm($urandom_range(1) ? $urandom_range(9) + 1 : $urandom | 1);
        else push_operand();
        op(k);
        op(OP_WRITE);
      end
      5: begin
        push_operand();
        push_operand();
        op(KIND_W'(OP_EQ + $urandom_range(3)));
        if (m_cnt > 0 && m_val[m_cnt - 1] != 0) jump_to(OP_JF, TGT_W'($urandom));
        else jump_to(OP_JF, TGT_W'($urandom_range(600)));
      end
      6: begin
        n = $urandom_range(12) + 1;
        for (int i = 0; i < n; i++) push_operand();
        for (int i = 1; i < n; i++) op($urandom_range(1) ? OP_ADD : OP_SUB);
        op(OP_WRITE);
      end
      default: begin
        it = rand_instr(OP_JUMP);
        it.opnd = 1'b1;
        it.tgt = TGT_W'($urandom_range(600));
        send(it);
      end
    endcase
    if (m_addr > 1200) jump_to(OP_JUMP, TGT_W'($urandom_range(100)));
  endfunction

  task automatic write_length(logic [ADDR_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_len = v;
  endtask

  task automatic drain();
    while (instr_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int items, int ip, int sp);
    idle_pct = ip;
    stall_pct = sp;
    while (instr_q.size() < items) random_sequence();
    drain();
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (instr_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_kind <= instr_q[0].kind;
        in_operand_present <= instr_q[0].opnd;
        in_immediate <= instr_q[0].imm;
        in_symbol_slot <= instr_q[0].sym;
        in_jump_target <= instr_q[0].tgt;
        in_read_value <= instr_q[0].rdv;
        void'(instr_q.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    status_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        got = {out_next_address, out_write_valid, out_write_value, out_run_status,
               out_fault_code};
        if (status_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transfer %p", got);
        end else begin
          want = status_q.pop_front();
          if (got != want) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    m_cnt = 0;
    m_addr = 0;
    m_steps = 0;
    m_len = 1;
    m_rs = RS_RUN;
    m_flt = FLT_NONE;
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      m_vars[i] = '0;
      m_asg[i] = 0;
    end
    for (int i = 0; i < ARRAY_CELLS; i++) m_arr[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_length(ADDR_W'(PROGRAM_DEPTH));

    arith(OP_ADD, 32'h7fffffff, 32'd1);
    arith(OP_SUB, 32'h80000000, 32'd1);
    arith(OP_MUL, 32'h7fffffff, 32'h7fffffff);
    arith(OP_DIV, 32'h80000000, 32'hffffffff);
    arith(OP_DIV, 32'hfffffff9, 32'd2);
    arith(OP_GT, 32'h80000000, 32'h7fffffff);
    push_sym(OP_PUSHV, 8'hff);
    op(OP_READ);
    push_elem(8'hff, ARRAY_LENGTH - 1);
    op(OP_WRITE);
    jump_to(OP_JUMP, 12'd0);
    drain();

    random_phase(300, 0, 0);
    write_length(13'h1fff);
    random_phase(300, 70, 0);
    write_length(13'd2000);
    random_phase(300, 0, 70);
    write_length(13'd3000);
    random_phase(300, 16, 16);

    // length of one: the step count is far past its limit now
    write_length(13'd1);
    for (int i = 0; i < 10; i++) op(KIND_W'($urandom));
    drain();

    if (errors == 0 && status_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
